@@ rtl/nscc_pkg.sv @@
// Shared types, character constants and header tables for the NMEA sentence
// classifier and checksum core. No dependencies; every file but nscc_if imports it.
`default_nettype none

package nscc_pkg;

    // Characters with a fixed meaning in a sentence.
    localparam logic [7:0] C_DOLLAR = 8'h24;
    localparam logic [7:0] C_STAR   = 8'h2A;
    localparam logic [7:0] C_TALKER = 8'h23;  // '#' marks the talker slot in a pattern

    // Header bookkeeping.
    localparam int unsigned HDR_TYPES = 12;
    localparam int unsigned HDR_MAX   = 10;
    localparam logic [4:0]  POS_MAX   = 5'd31;

    // Sentence type codes.
    localparam logic [3:0] TYPE_UNKNOWN = 4'd0;
    localparam logic [3:0] TYPE_PLSR_1  = 4'd1;
    localparam logic [3:0] TYPE_PLSR_2  = 4'd2;
    localparam logic [3:0] TYPE_PLSR_7  = 4'd3;
    localparam logic [3:0] TYPE_GGA     = 4'd4;
    localparam logic [3:0] TYPE_GSA     = 4'd5;
    localparam logic [3:0] TYPE_GSV     = 4'd6;
    localparam logic [3:0] TYPE_RMC     = 4'd7;
    localparam logic [3:0] TYPE_VTG     = 4'd8;
    localparam logic [3:0] TYPE_TXT     = 4'd9;
    localparam logic [3:0] TYPE_GLL     = 4'd10;
    localparam logic [3:0] TYPE_HEADING = 4'd11;

    // Header patterns, left justified in ten character slots.
    localparam logic [79:0] HDR_PAT [HDR_TYPES] = '{
        80'h0,
        "PLSR,245,1",
        "PLSR,245,2",
        "PLSR,245,7",
        {"G#GGA", 40'h0},
        {"G#GSA", 40'h0},
        {"G#GSV", 40'h0},
        {"G#RMC", 40'h0},
        {"G#VTG", 40'h0},
        {"G#TXT", 40'h0},
        {"G#GLL", 40'h0},
        {"HCHDG", 40'h0}
    };
    localparam logic [4:0] HDR_LEN [HDR_TYPES] = '{
        5'd0, 5'd10, 5'd10, 5'd10, 5'd5, 5'd5, 5'd5, 5'd5, 5'd5, 5'd5, 5'd5, 5'd5
    };

    // One accepted beat as it leaves the input register.
    typedef struct packed {
        logic       go;
        logic       last;
        logic [7:0] ch;
    } t_step;

    // What the header unit reports to the rest of the core.
    typedef struct packed {
        logic       first;
        logic [3:0] stype;
        logic [7:0] talker;
    } t_hdr_res;

    // What the checksum unit reports.
    typedef struct packed {
        logic [7:0] computed;
        logic [7:0] received;
        logic       match;
    } t_sum_res;

    // Expected character of header row t at sentence position p (1 to 10).
    function automatic logic [7:0] hdr_char(input int unsigned t, input logic [3:0] p);
        logic [79:0] row;
        logic [3:0]  slot;
        row  = HDR_PAT[t];
        slot = 4'd10 - p;
        return row[{slot, 3'b000} +: 8];
    endfunction

    // Talker letters accepted in the G sentences.
    function automatic logic is_talker(input logic [7:0] c);
        return c == "P" || c == "A" || c == "L" || c == "B" || c == "I" || c == "Q";
    endfunction

    // Hex digit decode: bit 4 set means the character is a valid digit.
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= "0" && c <= "9") begin
            r = {1'b1, 4'(c - "0")};
        end else if (c >= "A" && c <= "F") begin
            r = {1'b1, 4'(c - "A" + 8'd10)};
        end else if (c >= "a" && c <= "f") begin
            r = {1'b1, 4'(c - "a" + 8'd10)};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ rtl/nscc_if.sv @@
// Valid/ready channel interfaces for the sentence core: character beats in,
// classification beats out. Depends on nothing.
`default_nettype none

interface nscc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;
    logic       end_of_sentence;

    modport source(output valid, char_in, end_of_sentence, input ready);
    modport sink(input valid, char_in, end_of_sentence, output ready);
endinterface

interface nscc_out_if;
    logic       valid;
    logic       ready;
    logic [3:0] sentence_type;
    logic [7:0] talker_letter;
    logic [7:0] computed_sum;
    logic [7:0] received_sum;
    logic       checksum_match;
    logic       sentence_valid;

    modport source(output valid, sentence_type, talker_letter, computed_sum,
                   received_sum, checksum_match, sentence_valid, input ready);
    modport sink(input valid, sentence_type, talker_letter, computed_sum,
                 received_sum, checksum_match, sentence_valid, output ready);
endinterface

`default_nettype wire

@@ rtl/nmea_sentence_classify_checksum_core.sv @@
// Top level of the NMEA sentence classifier and checksum core.
// Depends on nscc_pkg, nscc_if, nscc_header and nscc_cksum.
//
//   Port     Dir  Beat carries                          Beats
//   i_in     in   char_in, end_of_sentence              one per character
//   o_out    out  type, talker, both sums, match, valid one per sentence
//
// One character is taken every cycle unless a final character waits on a full
// output register; a beat passes an input register, then the header and checksum
// logic, and the result lands in an output register when its final character
// leaves the input register.
// Only a final character waits on a full output register; other characters
// move on regardless of o_out.ready. Reset is synchronous, active low.
`default_nettype none

module nmea_sentence_classify_checksum_core
    import nscc_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    nscc_in_if.sink   i_in,
    nscc_out_if.source o_out
);

    logic       r_s1_valid;
    logic       r_s1_last;
    logic [7:0] r_s1_ch;
    logic       out_free;
    logic       s1_go;
    t_step      step;
    t_hdr_res   hdr;
    t_sum_res   sum;

    logic       r_out_valid;
    logic [3:0] r_type;
    logic [7:0] r_talker;
    logic [7:0] r_computed;
    logic [7:0] r_received;
    logic       r_match;
    logic       r_valid_flag;

    // Flow control: a final character needs room in the output register.
    assign out_free   = !r_out_valid || o_out.ready;
    assign s1_go      = r_s1_valid && (!r_s1_last || out_free);
    assign i_in.ready = !r_s1_valid || s1_go;

    assign step.go   = s1_go;
    assign step.last = r_s1_last;
    assign step.ch   = r_s1_ch;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_s1_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_s1_ch   <= i_in.char_in;
            r_s1_last <= i_in.end_of_sentence;
        end
    end

    nscc_header u_header (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .o_res   (hdr)
    );

    nscc_cksum u_cksum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_first (hdr.first),
        .o_res   (sum)
    );

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_go && r_s1_last) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go && r_s1_last) begin
            r_type       <= hdr.stype;
            r_talker     <= hdr.talker;
            r_computed   <= sum.computed;
            r_received   <= sum.received;
            r_match      <= sum.match;
            r_valid_flag <= (hdr.stype != TYPE_UNKNOWN) && sum.match;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.sentence_type  = r_type;
    assign o_out.talker_letter  = r_talker;
    assign o_out.computed_sum   = r_computed;
    assign o_out.received_sum   = r_received;
    assign o_out.checksum_match = r_match;
    assign o_out.sentence_valid = r_valid_flag;

endmodule

`default_nettype wire

@@ rtl/nscc_header.sv @@
// Header matcher: character position, per-type match flags and talker letter.
// Depends on nscc_pkg.
`default_nettype none

module nscc_header
    import nscc_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_step    i_step,
    output t_hdr_res      o_res
);

    logic [4:0]  r_pos, n_pos;
    logic [11:0] r_flags, n_flags;
    logic [7:0]  r_talker, n_talker;
    logic [3:0]  stype;
    logic        first;

    assign first = (r_pos == 5'd0);

    // Next state for one character.
    always_comb begin
        n_pos    = (r_pos < POS_MAX) ? r_pos + 5'd1 : r_pos;
        n_talker = (r_pos == 5'd2) ? i_step.ch : r_talker;
        n_flags  = r_flags;
        if (first) begin
            if (i_step.ch != C_DOLLAR) begin
                n_flags = '0;
            end
        end else if (r_pos <= 5'(HDR_MAX)) begin
            for (int unsigned t = 1; t < HDR_TYPES; t++) begin
                if (r_pos <= HDR_LEN[t]) begin
                    if (hdr_char(t, r_pos[3:0]) == C_TALKER) begin
                        if (!is_talker(i_step.ch)) n_flags[t] = 1'b0;
                    end else if (i_step.ch != hdr_char(t, r_pos[3:0])) begin
                        n_flags[t] = 1'b0;
                    end
                end
            end
        end
    end

    // Lowest numbered type whose whole header matched wins.
    always_comb begin
        stype = TYPE_UNKNOWN;
        for (int unsigned t = HDR_TYPES - 1; t >= 1; t--) begin
            if (n_flags[t] && n_pos > HDR_LEN[t]) stype = 4'(t);
        end
    end

    always_comb begin
        o_res.first  = first;
        o_res.stype  = stype;
        o_res.talker = (stype >= TYPE_GGA && stype <= TYPE_GLL) ? n_talker : 8'd0;
    end

    // State registers; the final character of a sentence returns them to reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= 5'd0;
            r_flags  <= '1;
            r_talker <= 8'd0;
        end else if (i_step.go) begin
            if (i_step.last) begin
                r_pos    <= 5'd0;
                r_flags  <= '1;
                r_talker <= 8'd0;
            end else begin
                r_pos    <= n_pos;
                r_flags  <= n_flags;
                r_talker <= n_talker;
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/nscc_cksum.sv @@
// Checksum unit: XOR accumulator up to the star and the hex digits after it.
// Depends on nscc_pkg.
`default_nettype none

module nscc_cksum
    import nscc_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_step i_step,
    input  wire logic  i_first,
    output t_sum_res   o_res
);

    logic [7:0] r_xor, n_xor;
    logic       r_star, n_star;
    logic [1:0] r_digits, n_digits;
    logic [7:0] r_hex, n_hex;
    logic       r_bad, n_bad;
    logic [4:0] digit;
    logic       good;
    logic [7:0] rsum;

    assign digit = hex_digit(i_step.ch);

    // Next state for one character; the leading character is never summed.
    always_comb begin
        n_xor    = r_xor;
        n_star   = r_star;
        n_digits = r_digits;
        n_hex    = r_hex;
        n_bad    = r_bad;
        if (!i_first) begin
            if (!r_star) begin
                if (i_step.ch == C_STAR) n_star = 1'b1;
                else n_xor = r_xor ^ i_step.ch;
            end else begin
                if (!digit[4]) n_bad = 1'b1;
                else if (r_digits < 2'd2) n_hex = {r_hex[3:0], digit[3:0]};
                if (r_digits != 2'd3) n_digits = r_digits + 2'd1;
            end
        end
    end

    // Well formed means a star followed by one or two hex digits only.
    always_comb begin
        good           = n_star && !n_bad && (n_digits == 2'd1 || n_digits == 2'd2);
        rsum           = good ? n_hex : 8'd0;
        o_res.computed = n_xor;
        o_res.received = rsum;
        o_res.match    = good && (rsum == n_xor);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_xor    <= 8'd0;
            r_star   <= 1'b0;
            r_digits <= 2'd0;
            r_hex    <= 8'd0;
            r_bad    <= 1'b0;
        end else if (i_step.go) begin
            if (i_step.last) begin
                r_xor    <= 8'd0;
                r_star   <= 1'b0;
                r_digits <= 2'd0;
                r_hex    <= 8'd0;
                r_bad    <= 1'b0;
            end else begin
                r_xor    <= n_xor;
                r_star   <= n_star;
                r_digits <= n_digits;
                r_hex    <= n_hex;
                r_bad    <= n_bad;
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/nscc_checker.sv @@
// Port-level checks for the sentence core, attached to the top level by bind.
// Depends on nscc_pkg and the top level's interface ports.
`default_nettype none

module nscc_port_checker
    import nscc_pkg::*;
(
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_out_valid,
    input wire logic       i_out_ready,
    input wire logic [3:0] i_type,
    input wire logic [7:0] i_talker,
    input wire logic [7:0] i_computed,
    input wire logic [7:0] i_received,
    input wire logic       i_match,
    input wire logic       i_valid_flag
);

    // A stalled result beat stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result beat dropped while stalled");

    // A valid sentence needs a known type and a matching checksum.
    a_valid_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_valid_flag |-> i_match && i_type != TYPE_UNKNOWN)
        else $error("sentence_valid without known type and match");

    // A match means both sums agree.
    a_match_sums: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_match |-> i_computed == i_received)
        else $error("checksum_match with differing sums");

    // Only the G sentences report a talker letter.
    a_talker: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_talker != 8'd0 |->
            (i_type == TYPE_GGA || i_type == TYPE_GSA || i_type == TYPE_GSV ||
             i_type == TYPE_RMC || i_type == TYPE_VTG || i_type == TYPE_TXT ||
             i_type == TYPE_GLL))
        else $error("talker letter on a non-G sentence");

endmodule

bind nmea_sentence_classify_checksum_core nscc_port_checker u_nscc_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_type       (o_out.sentence_type),
    .i_talker     (o_out.talker_letter),
    .i_computed   (o_out.computed_sum),
    .i_received   (o_out.received_sum),
    .i_match      (o_out.checksum_match),
    .i_valid_flag (o_out.sentence_valid)
);

`default_nettype wire

@@ verif/nscc_checker.sv @@
// Checker for the NMEA sentence classifier and checksum core: watches both
// channels, predicts one result per finished sentence and compares fields.
// Depends on nscc_pkg and the channel interfaces in nscc_if.
`default_nettype none

module nscc_checker
    import nscc_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    nscc_in_if        i_in_mon,
    nscc_out_if       i_out_mon,
    output int        o_fail_count,
    output int        o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // One classification as the core should report it.
    typedef struct packed {
        logic [3:0] stype;
        logic [7:0] talker;
        logic [7:0] calc_sum;
        logic [7:0] rx_sum;
        logic       match;
        logic       valid;
    } t_sentence_result;

    // Header text per row; '#' stands for the talker letter.
    string header_text [12] = '{
        "", "PLSR,245,1", "PLSR,245,2", "PLSR,245,7",
        "G#GGA", "G#GSA", "G#GSV", "G#RMC", "G#VTG", "G#TXT", "G#GLL", "HCHDG"
    };
    logic [3:0] header_code [12] = '{
        TYPE_UNKNOWN, TYPE_PLSR_1, TYPE_PLSR_2, TYPE_PLSR_7, TYPE_GGA, TYPE_GSA,
        TYPE_GSV, TYPE_RMC, TYPE_VTG, TYPE_TXT, TYPE_GLL, TYPE_HEADING
    };

    // Sentence tracking state of the prediction.
    logic [4:0]  pos_cnt;
    logic [11:0] hdr_live;
    logic [7:0]  talker_q;
    logic [7:0]  xor_q;
    logic        star_q;
    logic [1:0]  digit_cnt;
    logic [7:0]  hex_q;
    logic        hex_bad_q;

    t_sentence_result sentence_q [$];
    t_sentence_result want;
    int fail_tally = 0;
    int pending_n  = 0;

    assign o_fail_count = fail_tally;
    assign o_pending    = pending_n;

    function automatic logic talker_ok(input logic [7:0] c);
        return c == "P" || c == "A" || c == "L" || c == "B" || c == "I" || c == "Q";
    endfunction

    // Returns the digit value, or -1 when the character is not hex.
    function automatic int hex_nibble(input logic [7:0] c);
        if (c >= "0" && c <= "9") return int'(c - "0");
        if (c >= "A" && c <= "F") return int'(c - "A") + 10;
        if (c >= "a" && c <= "f") return int'(c - "a") + 10;
        return -1;
    endfunction

    task automatic clear_sentence();
        pos_cnt   = '0;
        hdr_live  = '1;
        talker_q  = '0;
        xor_q     = '0;
        star_q    = 1'b0;
        digit_cnt = '0;
        hex_q     = '0;
        hex_bad_q = 1'b0;
    endtask

    task automatic flag_error(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        fail_tally++;
    endtask

    task automatic check_field(input string name, input int got, input int exp_val);
        if (got != exp_val) begin
            flag_error($sformatf("%s got 0x%0h, want 0x%0h", name, got, exp_val));
        end
    endtask

    // Advance the sentence state by one character; a final character
    // closes the sentence and queues its classification.
    task automatic take_char(input logic [7:0] c, input logic last);
        t_sentence_result res;
        logic [7:0] pat;
        logic       ok;
        logic       good;
        logic       found;
        int         d;
        if (pos_cnt == 0) begin
            if (c != C_DOLLAR) hdr_live = '0;
        end else begin
            if (pos_cnt == 2) talker_q = c;
            if (pos_cnt <= HDR_MAX) begin
                for (int row = 1; row < 12; row++) begin
                    if (pos_cnt <= header_text[row].len()) begin
                        pat = header_text[row][pos_cnt - 1];
                        ok  = (pat == C_TALKER) ? talker_ok(c) : (c == pat);
                        if (!ok) hdr_live[row] = 1'b0;
                    end
                end
            end
            if (!star_q) begin
                if (c == C_STAR) star_q = 1'b1;
                else xor_q ^= c;
            end else begin
                d = hex_nibble(c);
                if (d < 0) hex_bad_q = 1'b1;
                else if (digit_cnt < 2) hex_q = {hex_q[3:0], 4'(d)};
                if (digit_cnt < 3) digit_cnt++;
            end
        end
        if (pos_cnt < POS_MAX) pos_cnt++;

        if (last) begin
            // First header row still alive whose text was fully received.
            res.stype = TYPE_UNKNOWN;
            found = 1'b0;
            for (int row = 1; row < 12; row++) begin
                if (!found && hdr_live[row] && pos_cnt > header_text[row].len()) begin
                    res.stype = header_code[row];
                    found = 1'b1;
                end
            end
            good = star_q && !hex_bad_q && digit_cnt >= 1 && digit_cnt <= 2;
            res.talker   = (res.stype >= TYPE_GGA && res.stype <= TYPE_GLL) ? talker_q : 8'h00;
            res.calc_sum = xor_q;
            res.rx_sum   = good ? hex_q : 8'h00;
            res.match    = good && (res.rx_sum == xor_q);
            res.valid    = (res.stype != TYPE_UNKNOWN) && res.match;
            sentence_q.push_back(res);
            clear_sentence();
        end
    endtask

    // Predict on accepted character beats, compare on accepted result beats.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_sentence();
            sentence_q.delete();
        end else begin
            if (i_in_mon.valid && i_in_mon.ready) begin
                take_char(i_in_mon.char_in, i_in_mon.end_of_sentence);
            end
            if (i_out_mon.valid && i_out_mon.ready) begin
                if (sentence_q.size() == 0) begin
                    flag_error("result beat with no sentence pending");
                end else begin
                    want = sentence_q.pop_front();
                    check_field("sentence_type", i_out_mon.sentence_type, want.stype);
                    check_field("talker_letter", i_out_mon.talker_letter, want.talker);
                    check_field("computed_sum", i_out_mon.computed_sum, want.calc_sum);
                    check_field("received_sum", i_out_mon.received_sum, want.rx_sum);
                    check_field("checksum_match", i_out_mon.checksum_match, want.match);
                    check_field("sentence_valid", i_out_mon.sentence_valid, want.valid);
                end
            end
        end
        pending_n <= sentence_q.size();
    end

endmodule

`default_nettype wire

@@ verif/tb.sv @@
// Top of the sentence core testbench: clock, reset, character stimulus and
// result back-pressure, and the final verdict.
// Depends on nscc_pkg, nscc_if, the core and nscc_checker.
`default_nettype none

module tb
    import nscc_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 8;

    logic i_clk = 1'b0;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    int   cycle_count = 0;
    int   send_idle_pct = 38;
    int   recv_idle_pct = 86;
    int   chars_sent = 0;

    logic [7:0] line_q [$];

    string header_text [11] = '{
        "PLSR,245,1", "PLSR,245,2", "PLSR,245,7", "G#GGA", "G#GSA", "G#GSV",
        "G#RMC", "G#VTG", "G#TXT", "G#GLL", "HCHDG"
    };
    string talkers = "PALBIQ";

    nscc_in_if  in_ch();
    nscc_out_if out_ch();

    nmea_sentence_classify_checksum_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    nscc_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_mon     (in_ch),
        .i_out_mon    (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #1 i_clk = ~i_clk;

    // Cycle guard against a hung handshake.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("nmea_sentence_classify_checksum_core verification failed");
            $finish;
        end
    end

    // Result back-pressure.
    always @(negedge i_clk) begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    function automatic logic [7:0] hex_char(input logic [3:0] n, input bit lower);
        if (n < 10) return 8'("0" + n);
        return lower ? 8'("a" + n - 10) : 8'("A" + n - 10);
    endfunction

    // XOR of everything after the leading character.
    function automatic logic [7:0] running_xor();
        logic [7:0] s;
        s = 8'h00;
        for (int i = 1; i < line_q.size(); i++) s ^= line_q[i];
        return s;
    endfunction

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++) line_q.push_back(s[i]);
    endtask

    // Well-formed checksum trailer for what is in the line so far.
    task automatic push_check(input bit lower);
        logic [7:0] s;
        s = running_xor();
        line_q.push_back(C_STAR);
        line_q.push_back(hex_char(s[7:4], lower));
        line_q.push_back(hex_char(s[3:0], lower));
    endtask

    task automatic push_payload(input int n);
        logic [7:0] c;
        repeat (n) begin
            if ($urandom_range(9) == 0) begin
                c = 8'($urandom_range(255));
            end else begin
                c = 8'($urandom_range(8'h20, 8'h7E));
                if (c == C_STAR) c = ",";
            end
            line_q.push_back(c);
        end
    endtask

    // One character beat, with a random gap in front of it.
    task automatic send_beat(input logic [7:0] ch, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid           <= 1'b1;
        in_ch.char_in         <= ch;
        in_ch.end_of_sentence <= last;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        chars_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_line();
        for (int i = 0; i < line_q.size(); i++) begin
            send_beat(line_q[i], i == line_q.size() - 1);
        end
        line_q.delete();
    endtask

    // Mostly well-formed sentences with random content, the rest broken or noise.
    task automatic build_random_line();
        int         kind;
        int         row;
        int         fault;
        bit         lower;
        string      hdr;
        logic [7:0] c;
        logic [7:0] s;
        kind = $urandom_range(99);
        if (kind >= 88) begin
            repeat ($urandom_range(1, 24)) line_q.push_back(8'($urandom_range(255)));
            return;
        end
        line_q.push_back(kind < 78 ? C_DOLLAR : 8'($urandom_range(255)));
        row = $urandom_range(10);
        hdr = header_text[row];
        for (int i = 0; i < hdr.len(); i++) begin
            c = hdr[i];
            if (c == C_TALKER) begin
                c = ($urandom_range(9) == 0) ? 8'($urandom_range(255))
                                             : talkers[$urandom_range(5)];
            end
            line_q.push_back(c);
        end
        if ($urandom_range(19) == 0) begin
            repeat ($urandom_range(1, hdr.len() - 1)) void'(line_q.pop_back());
        end
        push_payload(($urandom_range(9) == 0) ? $urandom_range(15, 30) : $urandom_range(0, 10));
        s     = running_xor();
        lower = $urandom_range(1);
        fault = $urandom_range(99);
        if (fault < 75) begin
            push_check(lower);
        end else if (fault < 79) begin
            // Wrong sum.
            s ^= 8'($urandom_range(1, 255));
            line_q.push_back(C_STAR);
            line_q.push_back(hex_char(s[7:4], lower));
            line_q.push_back(hex_char(s[3:0], lower));
        end else if (fault < 83) begin
            // One digit only.
            line_q.push_back(C_STAR);
            line_q.push_back(hex_char(s[3:0], lower));
        end else if (fault < 87) begin
            // Three digits.
            push_check(lower);
            line_q.push_back(hex_char(4'($urandom_range(15)), lower));
        end else if (fault < 90) begin
            // A non-hex character among the digits.
            c = 8'($urandom_range(255));
            if ((c >= "0" && c <= "9") || (c >= "A" && c <= "F") || (c >= "a" && c <= "f"))
                c = "G";
            line_q.push_back(C_STAR);
            if ($urandom_range(1)) line_q.push_back(hex_char(s[7:4], lower));
            line_q.push_back(c);
        end else if (fault < 96) begin
            // No star at all, or a star with nothing after it.
            if (fault >= 93) line_q.push_back(C_STAR);
        end else begin
            // Second star after one digit.
            line_q.push_back(C_STAR);
            line_q.push_back(hex_char(s[7:4], lower));
            line_q.push_back(C_STAR);
        end
    endtask

    // Every header, each talker, and the malformed and odd cases.
    task automatic send_directed();
        push_text("$GPGGA,1");   push_check(1'b0); send_line();
        push_text("$GAGSA");     push_check(1'b1); send_line();
        push_text("$GLGSV,3");   push_check(1'b0); send_line();
        push_text("$GBRMC");     push_check(1'b1); send_line();
        push_text("$GIVTG");     push_check(1'b0); send_line();
        push_text("$GQTXT");     push_check(1'b1); send_line();
        push_text("$GPGLL");     push_check(1'b0); send_line();
        push_text("$PLSR,245,1"); push_check(1'b0); send_line();
        push_text("$PLSR,245,2"); push_check(1'b1); send_line();
        push_text("$PLSR,245,7"); push_check(1'b0); send_line();
        push_text("$HCHDG");     push_check(1'b0); send_line();
        // Wrong leading character, then a star in the leading slot.
        push_text("#GPGGA");     push_check(1'b0); send_line();
        push_text("*GPGGA");     push_check(1'b0); send_line();
        // Header cut short, and a lone dollar.
        push_text("$GPG");       send_line();
        push_text("$");          send_line();
        line_q.push_back(8'hFF); send_line();
        // Dollar inside the data and the byte extremes.
        push_text("$GPRMC,$");
        line_q.push_back(8'h00);
        line_q.push_back(8'hFF);
        push_check(1'b1);        send_line();
        // Broken trailers.
        push_text("$GPRMC*1*");  send_line();
        push_text("$HCHDG");     push_check(1'b0); push_text("0"); send_line();
        push_text("$GPVTG");     send_line();
        push_text("$GPVTG*");    send_line();
        push_text("$GPTXT*Z0");  send_line();
        push_text("$GXGGA");     push_check(1'b0); send_line();
        // Longer than the position counter holds.
        push_text("$GPGGA,0123456789,0123456789,0123456789");
        push_check(1'b1);        send_line();
    endtask

    initial begin
        i_rst_n               = 1'b0;
        in_ch.valid           = 1'b0;
        in_ch.char_in         = 8'h00;
        in_ch.end_of_sentence = 1'b0;
        out_ch.ready          = 1'b0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Three back-pressure phases: receiver slow, sender slow, neither.
        send_directed();
        while (chars_sent < 700) begin
            build_random_line();
            send_line();
        end
        send_idle_pct = 86;
        recv_idle_pct = 38;
        while (chars_sent < 1400) begin
            build_random_line();
            send_line();
        end
        send_idle_pct = 0;
        recv_idle_pct = 0;
        while (chars_sent < 2100) begin
            build_random_line();
            send_line();
        end
        in_ch.valid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("nmea_sentence_classify_checksum_core verification clean");
        end else begin
            $display("nmea_sentence_classify_checksum_core verification failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

@@ filelist.f @@
rtl/nscc_pkg.sv
rtl/nscc_if.sv
rtl/nscc_header.sv
rtl/nscc_cksum.sv
rtl/nmea_sentence_classify_checksum_core.sv
rtl/nscc_checker.sv
verif/nscc_checker.sv
verif/tb.sv
